@@ hw/rtl/alpct_pkg.sv @@
// ----------------------------------------------------------------------------
// alpct_pkg
// Shared types and codes for the allreduce phase completion tracker.
// ----------------------------------------------------------------------------
package alpct_pkg;

  localparam int unsigned DATA_W  = 40;
  localparam int unsigned DEST_W  = 16;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned DC_W    = 9;
  localparam int unsigned RPN_W   = 5;
  localparam int unsigned NODES_W = 7;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned PROD_W  = 47;
  localparam int unsigned DIV_STEPS = 40;

  // input actions / classified request codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BEGIN  = 2'd1;
  localparam logic [1:0] OP_ARRIVE = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  // phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_LOCAL_RS = 3'd1;
  localparam logic [2:0] PH_INTER_RS = 3'd2;
  localparam logic [2:0] PH_INTER_AG = 3'd3;
  localparam logic [2:0] PH_LOCAL_AG = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  // status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOPHASE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RPN   = 3'd0;
  localparam logic [2:0] CFG_NODES = 3'd1;
  localparam logic [2:0] CFG_TOTAL = 3'd2;
  localparam logic [2:0] CFG_BYTES = 3'd3;
  localparam logic [2:0] CFG_FM    = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [DEST_W-1:0]  dest;
    logic [BYTES_W-1:0] bytes;
  } item_t;

  typedef struct packed {
    logic [RPN_W-1:0]   rpn;
    logic [NODES_W-1:0] nodes;
    logic [TOTAL_W-1:0] total;
    logic [DATA_W-1:0]  data_bytes;
    logic               fullmesh;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DATA_W-1:0]  dividend;
    logic [NODES_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [2:0]      phase;
    logic            rank_fin;
    logic            phase_fin;
    logic            coll_fin;
    logic [DC_W-1:0] finished;
    logic [1:0]      status;
  } result_t;

endpackage

@@ hw/rtl/alpct_ram.sv @@
// ----------------------------------------------------------------------------
// alpct_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module alpct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/alpct_div.sv @@
// ----------------------------------------------------------------------------
// alpct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alpct_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alpct_pkg::div_req_t req_i,
  output alpct_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = alpct_pkg::DATA_W;
  localparam int unsigned VW = alpct_pkg::NODES_W;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dsr_q;
  logic [VW:0]   rem_sh, rem_n;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_n  = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'(alpct_pkg::DIV_STEPS - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(alpct_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_n[VW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ hw/rtl/alpct_front.sv @@
// ----------------------------------------------------------------------------
// alpct_front
// Input acceptance, request classification and a two-entry request queue.
// ----------------------------------------------------------------------------
module alpct_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [alpct_pkg::DEST_W-1:0]      dest_rank_i,
  input  logic [alpct_pkg::BYTES_W-1:0]     effective_bytes_i,
  input  logic [alpct_pkg::BYTES_W-1:0]     payload_bytes_i,
  output logic                              item_valid_o,
  output alpct_pkg::item_t                  item_o,
  input  logic                              item_pop_i
);

  alpct_pkg::item_t q_q [2];
  alpct_pkg::item_t new_item;
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  always_comb begin
    new_item.dest  = dest_rank_i;
    new_item.bytes = (effective_bytes_i != '0) ? effective_bytes_i : payload_bytes_i;
    case (action_i)
      alpct_pkg::OP_START:  new_item.op = alpct_pkg::OP_START;
      alpct_pkg::OP_BEGIN:  new_item.op = alpct_pkg::OP_BEGIN;
      alpct_pkg::OP_ARRIVE: new_item.op = alpct_pkg::OP_ARRIVE;
      default:              new_item.op = alpct_pkg::OP_BAD;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = q_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= new_item;
    end
  end

endmodule

@@ hw/rtl/alpct_back.sv @@
// ----------------------------------------------------------------------------
// alpct_back
// Request execution: size division, phase entry with table sweep, counter
// read-modify-write and the result register.
// ----------------------------------------------------------------------------
module alpct_back #(
  parameter int unsigned MAX_RANKS   = 256,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alpct_pkg::cfg_t               cfg_i,
  input  logic                          item_valid_i,
  input  alpct_pkg::item_t              item_i,
  output logic                          item_pop_o,
  output alpct_pkg::div_req_t           div_req_o,
  input  alpct_pkg::div_rsp_t           div_rsp_i,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [$clog2(MAX_RANKS)-1:0]  ram_addr_o,
  output logic [COUNT_WIDTH:0]          ram_wdata_o,
  input  logic [COUNT_WIDTH:0]          ram_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output alpct_pkg::result_t            res_o
);

  localparam int unsigned AW = $clog2(MAX_RANKS);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned PW = alpct_pkg::PROD_W;
  localparam int unsigned EW = (CW > PW) ? CW : PW;
  localparam int unsigned DW = alpct_pkg::DATA_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   dstep_q, dstep_d;
  logic [2:0]                   phase_q, phase_d, target_q, target_d;
  logic                         latch_q, latch_d;
  logic [alpct_pkg::DC_W-1:0]   dc_q, dc_d, dc_inc;
  logic [CW-1:0]                exp_q, exp_d;
  logic [DW-1:0]                seg_q, seg_d, inter_q, inter_d, ring_q, ring_d;
  logic [PW-1:0]                prod_q, prod_d;
  logic [AW-1:0]                clr_q, clr_d, dest_q, dest_d;
  logic [alpct_pkg::BYTES_W-1:0] bytes_q, bytes_d;
  logic [1:0]                   status_q, status_d;
  logic                         out_valid_q;
  alpct_pkg::result_t           out_q, out_d;
  logic                         out_load, out_free;

  logic [alpct_pkg::RPN_W-1:0]   rpn1, rpnm1;
  logic [alpct_pkg::NODES_W-1:0] nodes1, nodesm1;
  logic [alpct_pkg::DEST_W-1:0]  act;
  logic [44:0]                   m_seg;
  logic [PW-1:0]                 m_int;
  logic [CW:0]                   sum;
  logic [CW-1:0]                 sat;
  logic                          reached;
  logic [EW-1:0]                 prod_e;

  always_comb begin
    rpn1    = (cfg_i.rpn == '0) ? alpct_pkg::RPN_W'(1) : cfg_i.rpn;
    nodes1  = (cfg_i.nodes == '0) ? alpct_pkg::NODES_W'(1) : cfg_i.nodes;
    rpnm1   = rpn1 - alpct_pkg::RPN_W'(1);
    nodesm1 = nodes1 - alpct_pkg::NODES_W'(1);
    act     = (alpct_pkg::DEST_W'(cfg_i.total) > alpct_pkg::DEST_W'(MAX_RANKS)) ?
              alpct_pkg::DEST_W'(MAX_RANKS) : alpct_pkg::DEST_W'(cfg_i.total);
    m_seg   = seg_q * rpnm1;
    m_int   = inter_q * nodesm1;
    sum     = {1'b0, ram_rdata_i[CW-1:0]} + (CW+1)'(bytes_q);
    sat     = sum[CW] ? CNT_MAX : sum[CW-1:0];
    reached = (sat >= exp_q) && !ram_rdata_i[CW];
    dc_inc  = dc_q + alpct_pkg::DC_W'(1);
    prod_e  = EW'(prod_q);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    dstep_d  = dstep_q;
    phase_d  = phase_q;
    target_d = target_q;
    latch_d  = latch_q;
    dc_d     = dc_q;
    exp_d    = exp_q;
    seg_d    = seg_q;
    inter_d  = inter_q;
    ring_d   = ring_q;
    prod_d   = prod_q;
    clr_d    = clr_q;
    dest_d   = dest_q;
    bytes_d  = bytes_q;
    status_d = status_q;
    item_pop_o = 1'b0;
    div_req_o  = '0;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    ram_addr_o = clr_q;
    ram_wdata_o = '0;
    out_load = 1'b0;
    out_d.phase     = phase_q;
    out_d.rank_fin  = 1'b0;
    out_d.phase_fin = 1'b0;
    out_d.coll_fin  = 1'b0;
    out_d.finished  = dc_q;
    out_d.status    = status_q;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          status_d   = alpct_pkg::ST_OK;
          case (item_i.op)
            alpct_pkg::OP_START: begin
              target_d = alpct_pkg::PH_LOCAL_RS;
              div_req_o.start    = 1'b1;
              div_req_o.dividend = cfg_i.data_bytes;
              div_req_o.divisor  = alpct_pkg::NODES_W'(rpn1);
              dstep_d  = 2'd0;
              state_d  = S_DIV;
            end
            alpct_pkg::OP_BEGIN: begin
              if (latch_q && (phase_q == alpct_pkg::PH_LOCAL_RS ||
                              phase_q == alpct_pkg::PH_INTER_RS ||
                              phase_q == alpct_pkg::PH_INTER_AG)) begin
                target_d = phase_q + 3'd1;
                state_d  = S_MUL;
              end else begin
                status_d = alpct_pkg::ST_REFUSED;
                state_d  = S_RES;
              end
            end
            alpct_pkg::OP_ARRIVE: begin
              if (phase_q == alpct_pkg::PH_IDLE || phase_q == alpct_pkg::PH_DONE) begin
                status_d = alpct_pkg::ST_NOPHASE;
                state_d  = S_RES;
              end else if (item_i.dest >= act) begin
                status_d = alpct_pkg::ST_RANGE;
                state_d  = S_RES;
              end else begin
                ram_re_o   = 1'b1;
                ram_addr_o = item_i.dest[AW-1:0];
                dest_d     = item_i.dest[AW-1:0];
                bytes_d    = item_i.bytes;
                state_d    = S_UPD;
              end
            end
            default: begin
              status_d = alpct_pkg::ST_REFUSED;
              state_d  = S_RES;
            end
          endcase
        end
      end
      S_UPD: begin
        if (out_free) begin
          ram_we_o    = 1'b1;
          ram_addr_o  = dest_q;
          ram_wdata_o = {ram_rdata_i[CW] | reached, sat};
          out_load    = 1'b1;
          state_d     = S_IDLE;
          if (reached) begin
            dc_d           = dc_inc;
            out_d.rank_fin = 1'b1;
            out_d.finished = dc_inc;
            if (alpct_pkg::DEST_W'(dc_inc) >= act) begin
              latch_d         = 1'b1;
              out_d.phase_fin = 1'b1;
              if (phase_q == alpct_pkg::PH_LOCAL_AG) begin
                phase_d        = alpct_pkg::PH_DONE;
                out_d.phase    = alpct_pkg::PH_DONE;
                out_d.coll_fin = 1'b1;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          case (dstep_q)
            2'd0: begin
              seg_d = div_rsp_i.quot;
              div_req_o.start    = 1'b1;
              div_req_o.dividend = div_rsp_i.quot;
              div_req_o.divisor  = nodes1;
              dstep_d = 2'd1;
            end
            2'd1: begin
              inter_d = div_rsp_i.quot;
              div_req_o.start    = 1'b1;
              div_req_o.dividend = seg_q;
              div_req_o.divisor  = alpct_pkg::NODES_W'(rpn1);
              dstep_d = 2'd2;
            end
            default: begin
              ring_d  = div_rsp_i.quot;
              state_d = S_MUL;
            end
          endcase
        end
      end
      S_MUL: begin
        if (target_q == alpct_pkg::PH_LOCAL_RS && !cfg_i.fullmesh) begin
          prod_d = PW'(ring_q);
        end else if (target_q == alpct_pkg::PH_LOCAL_RS ||
                     target_q == alpct_pkg::PH_LOCAL_AG) begin
          prod_d = PW'(m_seg);
        end else begin
          prod_d = m_int;
        end
        state_d = S_SAT;
      end
      S_SAT: begin
        if (prod_q == '0) begin
          exp_d = CW'(1);
        end else if (prod_e > EW'(CNT_MAX)) begin
          exp_d = CNT_MAX;
        end else begin
          exp_d = CW'(prod_q);
        end
        phase_d = target_q;
        dc_d    = '0;
        latch_d = 1'b0;
        clr_d   = '0;
        state_d = S_CLR;
      end
      S_CLR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(MAX_RANKS - 1)) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dstep_q     <= '0;
      phase_q     <= alpct_pkg::PH_IDLE;
      target_q    <= alpct_pkg::PH_IDLE;
      latch_q     <= 1'b0;
      dc_q        <= '0;
      exp_q       <= CW'(1);
      seg_q       <= '0;
      inter_q     <= '0;
      clr_q       <= '0;
      status_q    <= alpct_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dstep_q  <= dstep_d;
      phase_q  <= phase_d;
      target_q <= target_d;
      latch_q  <= latch_d;
      dc_q     <= dc_d;
      exp_q    <= exp_d;
      seg_q    <= seg_d;
      inter_q  <= inter_d;
      clr_q    <= clr_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q  <= ring_d;
    prod_q  <= prod_d;
    dest_q  <= dest_d;
    bytes_q <= bytes_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ hw/rtl/allreduce_phase_completion_tracker_unit.sv @@
// A chunk arrival reads the rank's counter from the single-port counter
// memory, then adds, compares and writes it back. A start request runs
// three divisions in the shared divider, each of 40 steps, then a multiply
// and saturate step, then a sweep of the counter memory that clears one
// rank per cycle. A begin request runs only the multiply, saturate and
// sweep. Refused or flagged requests go straight to the result register.
// There is no clearing pass after reset: the counter memory is only read
// once a start has swept it. Requests queue two deep ahead of execution
// and results sit in an output register.
// ----------------------------------------------------------------------------
// allreduce_phase_completion_tracker_unit
// Phase completion tracker for a hierarchical allreduce.
// ----------------------------------------------------------------------------
module allreduce_phase_completion_tracker_unit #(
  parameter int unsigned MAX_RANKS   = 256,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [alpct_pkg::DATA_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [alpct_pkg::DEST_W-1:0]  dest_rank_i,
  input  logic [alpct_pkg::BYTES_W-1:0] effective_bytes_i,
  input  logic [alpct_pkg::BYTES_W-1:0] payload_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    phase_o,
  output logic                          rank_finished_o,
  output logic                          phase_finished_o,
  output logic                          collective_finished_o,
  output logic [alpct_pkg::DC_W-1:0]    finished_ranks_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned AW = $clog2(MAX_RANKS);

  alpct_pkg::cfg_t      cfg_q;
  alpct_pkg::item_t     item;
  alpct_pkg::div_req_t  div_req;
  alpct_pkg::div_rsp_t  div_rsp;
  alpct_pkg::result_t   res;
  logic                 item_valid, item_pop;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [COUNT_WIDTH:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpn        <= alpct_pkg::RPN_W'(8);
      cfg_q.nodes      <= alpct_pkg::NODES_W'(1);
      cfg_q.total      <= alpct_pkg::TOTAL_W'(8);
      cfg_q.data_bytes <= '0;
      cfg_q.fullmesh   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alpct_pkg::CFG_RPN:   cfg_q.rpn        <= cfg_data_i[alpct_pkg::RPN_W-1:0];
        alpct_pkg::CFG_NODES: cfg_q.nodes      <= cfg_data_i[alpct_pkg::NODES_W-1:0];
        alpct_pkg::CFG_TOTAL: cfg_q.total      <= cfg_data_i[alpct_pkg::TOTAL_W-1:0];
        alpct_pkg::CFG_BYTES: cfg_q.data_bytes <= cfg_data_i;
        alpct_pkg::CFG_FM:    cfg_q.fullmesh   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  alpct_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .dest_rank_i       (dest_rank_i),
    .effective_bytes_i (effective_bytes_i),
    .payload_bytes_i   (payload_bytes_i),
    .item_valid_o      (item_valid),
    .item_o            (item),
    .item_pop_i        (item_pop)
  );

  alpct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  alpct_ram #(
    .WIDTH (COUNT_WIDTH + 1),
    .DEPTH (MAX_RANKS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  alpct_back #(
    .MAX_RANKS   (MAX_RANKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign phase_o               = res.phase;
  assign rank_finished_o       = res.rank_fin;
  assign phase_finished_o      = res.phase_fin;
  assign collective_finished_o = res.coll_fin;
  assign finished_ranks_o      = res.finished;
  assign status_o              = res.status;

`ifndef SYNTH
  a_coll_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && collective_finished_o |-> phase_o == alpct_pkg::PH_DONE)
    else $error("collective finish without complete phase");

  a_phase_needs_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_finished_o |-> rank_finished_o)
    else $error("phase finish without rank finish");

  a_err_no_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != alpct_pkg::ST_OK |-> !rank_finished_o)
    else $error("finish reported on flagged request");
`endif

endmodule
